### hdl/dcmf_pkg.sv
`timescale 1ns / 1ps
// Package for the dark channel min filter: sizes, register defaults and
// register indexes. No dependencies.
package dcmf_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_WINDOW_DEF = 31;

  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;
  localparam logic [4:0]  WINDOW_RESET = 5'd15;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;

  localparam logic [7:0] PIX_MAX = 8'd255;

endpackage

### hdl/dark_channel_min_filter.sv
`timescale 1ns / 1ps
// Steps: an accepted word is checked; if the next result is due, its clipped window (rows x cols,
//   at most window_size squared) is scanned with one line-store read per cycle, drained, then put.
// Input: one word at a time; in_stall holds until the block is idle again, after the check for a word
//   with no result due, after the put for one with a result, longer while the result word is stalled.
// Reset: registers back to 640 x 480, window 15, frame position counters zero; line store not cleared.
// Depends on dcmf_pkg.
module dark_channel_min_filter #(
  parameter int MAX_WIDTH  = dcmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = dcmf_pkg::MAX_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  blue,
  input  logic [7:0]  green,
  input  logic [7:0]  red,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  dark_value,
  output logic        frame_end
);

  localparam int CW    = $clog2(MAX_WIDTH);       // column index bits
  localparam int WW    = $clog2(MAX_WINDOW + 1);  // window size bits
  localparam int SB    = WW;                      // row slot bits, 2**SB >= MAX_WINDOW+1
  localparam int DEPTH = (1 << SB) * (1 << CW);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SCAN, S_DRAIN, S_PUT} state_t;

  state_t state;

  // config registers
  logic [11:0] cfg_width, cfg_height;
  logic [4:0]  cfg_window;

  // frame position
  logic [11:0]   in_row, out_row;
  logic [CW-1:0] in_col, out_col;

  // scan bounds and position
  logic [11:0]   r1, p;
  logic [CW-1:0] c0, c1, q;
  logic [7:0]    acc;

  // line store of per-pixel channel minima
  logic [7:0]       mem [DEPTH];
  logic             wr_en, rd_en, rd_pend;
  logic [SB+CW-1:0] wr_addr, rd_addr;
  logic [7:0]       wr_data, rd_data;

  // effective geometry
  logic [CW:0]   w_eff;
  logic [11:0]   h_eff;
  logic [WW-1:0] s_eff, lead, after;

  always_comb begin
    if (cfg_width == 12'd0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(cfg_width);
    end
    h_eff = (cfg_height == 12'd0) ? 12'd1 : cfg_height;
    if (cfg_window == 5'd0) begin
      s_eff = WW'(1);
    end else if (32'(cfg_window) > 32'(MAX_WINDOW)) begin
      s_eff = WW'(MAX_WINDOW);
    end else begin
      s_eff = WW'(cfg_window);
    end
    lead  = s_eff >> 1;
    after = s_eff - WW'(1) - lead;  // even windows reach one less forward
  end

  // input side
  logic          accept, store_pix, col_wrap;
  logic [7:0]    pix_min;
  logic [CW:0]   in_col_inc;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign store_pix = accept && !mode && (in_row < h_eff);
  assign cfg_ready = 1'b1;

  always_comb begin
    pix_min = blue;
    if (green < pix_min) pix_min = green;
    if (red < pix_min)   pix_min = red;
  end

  assign in_col_inc = {1'b0, in_col} + (CW+1)'(1);
  assign col_wrap   = (in_col_inc >= w_eff);

  assign wr_en   = store_pix;
  assign wr_addr = {in_row[SB-1:0], in_col};
  assign wr_data = pix_min;

  // readiness check for the next output pixel
  logic [12:0]   need_r_raw;
  logic [11:0]   need_r, r0;
  logic [CW+1:0] need_c_raw;
  logic [CW-1:0] need_c, c0_calc;
  logic          win_ready;

  always_comb begin
    need_r_raw = {1'b0, out_row} + 13'(after);
    need_r = (need_r_raw > 13'(h_eff - 12'd1)) ? (h_eff - 12'd1) : need_r_raw[11:0];
    need_c_raw = (CW+2)'(out_col) + (CW+2)'(after);
    need_c = (need_c_raw > (CW+2)'(w_eff - (CW+1)'(1))) ?
             CW'(w_eff - (CW+1)'(1)) : need_c_raw[CW-1:0];
    win_ready = (out_row < h_eff) &&
                ((in_row > need_r) || ((in_row == need_r) && ({1'b0, in_col} > (CW+1)'(need_c))));
    r0 = (out_row >= 12'(lead)) ? (out_row - 12'(lead)) : 12'd0;
    c0_calc = ((CW+1)'(out_col) >= (CW+1)'(lead)) ?
              CW'((CW+1)'(out_col) - (CW+1)'(lead)) : CW'(0);
  end

  assign rd_en   = (state == S_SCAN);
  assign rd_addr = {p[SB-1:0], q};

  // line store
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  logic out_last, put_fire;
  assign out_last = (out_row == h_eff - 12'd1) && ({1'b0, out_col} == w_eff - (CW+1)'(1));
  // result word leaves the put state this cycle
  assign put_fire = (state == S_PUT) && !(cfg_valid && cfg_ready) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cfg_width  <= dcmf_pkg::WIDTH_RESET;
      cfg_height <= dcmf_pkg::HEIGHT_RESET;
      cfg_window <= dcmf_pkg::WINDOW_RESET;
      in_row     <= '0;
      in_col     <= '0;
      out_row    <= '0;
      out_col    <= '0;
      out_valid  <= 1'b0;
      rd_pend    <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      if (rd_pend && rd_data < acc) acc <= rd_data;
      if (put_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          dcmf_pkg::REG_WIDTH:  cfg_width  <= cfg_data;
          dcmf_pkg::REG_HEIGHT: cfg_height <= cfg_data;
          dcmf_pkg::REG_WINDOW: cfg_window <= cfg_data[4:0];
          default: ;
        endcase
        // any write restarts the frame
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (accept) begin
              if (store_pix) begin
                if (col_wrap) begin
                  in_col <= '0;
                  in_row <= in_row + 12'd1;
                end else begin
                  in_col <= in_col_inc[CW-1:0];
                end
              end
              state <= S_CHECK;
            end
          end
          S_CHECK: begin
            if (win_ready) begin
              p     <= r0;
              q     <= c0_calc;
              c0    <= c0_calc;
              r1    <= need_r;
              c1    <= need_c;
              acc   <= dcmf_pkg::PIX_MAX;
              state <= S_SCAN;
            end else begin
              state <= S_IDLE;
            end
          end
          S_SCAN: begin
            if (p == r1 && q == c1) begin
              state <= S_DRAIN;
            end else if (q == c1) begin
              q <= c0;
              p <= p + 12'd1;
            end else begin
              q <= q + CW'(1);
            end
          end
          S_DRAIN: begin
            state <= S_PUT;  // last read folds in this cycle
          end
          S_PUT: begin
            if (!out_valid || !out_stall) begin
              dark_value <= acc;
              frame_end  <= out_last;
              if (out_last) begin
                in_row  <= '0;
                in_col  <= '0;
                out_row <= '0;
                out_col <= '0;
              end else if ({1'b0, out_col} + (CW+1)'(1) >= w_eff) begin
                out_col <= '0;
                out_row <= out_row + 12'd1;
              end else begin
                out_col <= out_col + CW'(1);
              end
              state <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule
